// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the trilinear grid sampler.
// No dependencies; include inside a module that has clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- src/tgs_pkg.sv -----
// Package of the trilinear grid sampler: field widths, beat layout and codes.
// No dependencies; used by trilinear_grid_sampler_top and its testbench.
package tgs_pkg;

  // Grid and number formats
  localparam int GRID_DIM    = 32;
  localparam int INT_BITS    = $clog2(GRID_DIM);
  localparam int FRAC_BITS   = 8;
  localparam int COORD_BITS  = INT_BITS + FRAC_BITS;
  localparam int SAMPLE_BITS = 16;
  localparam int REG_BITS    = 6;
  localparam int ADDR_BITS   = 3 * INT_BITS;
  localparam int GRID_DEPTH  = GRID_DIM * GRID_DIM * GRID_DIM;

  // Blend datapath widths
  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + FRAC_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS - FRAC_BITS;

  // Input beat layout
  localparam int CMD_BITS     = 2;
  localparam int S_CMD_LSB    = 0;
  localparam int S_X_LSB      = S_CMD_LSB + CMD_BITS;
  localparam int S_Y_LSB      = S_X_LSB + COORD_BITS;
  localparam int S_Z_LSB      = S_Y_LSB + COORD_BITS;
  localparam int S_SAMPLE_LSB = S_Z_LSB + COORD_BITS;
  localparam int S_USED_BITS  = S_SAMPLE_LSB + SAMPLE_BITS;
  localparam int S_TDATA_BITS = ((S_USED_BITS + 7) / 8) * 8;

  // Output beat layout
  localparam int M_VALUE_LSB  = 0;
  localparam int M_STATUS_LSB = SAMPLE_BITS;
  localparam int M_USED_BITS  = SAMPLE_BITS + 1;
  localparam int M_TDATA_BITS = ((M_USED_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_INTERP = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH_USED  = 2'd0,
    CFG_HEIGHT_USED = 2'd1,
    CFG_DEPTH_USED  = 2'd2
  } cfg_idx_e;

endpackage

// ----- src/trilinear_grid_sampler_top.sv -----
// Top level of the trilinear grid sampler: sample store, sequencer, blend unit.
// Depends on tgs_pkg, tgs_ram and assert_macros.svh.
//
//  channel | dir | handshake                         | beat fields
//  --------+-----+-----------------------------------+-----------------------------------
//  s_axis  | in  | s_axis_tvalid_i / s_axis_tready_o | cmd, x/y/z_coord, sample_in
//  m_axis  | out | m_axis_tvalid_o / m_axis_tready_i | value_out, status
//  cfg     | in  | cfg_we_i, no back-pressure        | cfg_idx_i, cfg_data_i
//
// One item at a time. An interpolated read makes eight corner fetches through
// the single RAM port, then the tail of seven blends through one registered
// multiply-add unit.
// Reset clears the grid size registers to 32 and the sequencer; the sample
// memory is not cleared. A result waiting on m_axis does not block the next
// accept; the sequencer holds in its done state only while the output is full.
module trilinear_grid_sampler_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [tgs_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [tgs_pkg::REG_BITS-1:0]       cfg_data_i,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata from bit 0: cmd[2], x_coord[13], y_coord[13], z_coord[13], sample_in[16], zero pad
  input  logic [tgs_pkg::S_TDATA_BITS-1:0]   s_axis_tdata_i,
  // output stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata from bit 0: value_out[16], status[1], zero pad
  output logic [tgs_pkg::M_TDATA_BITS-1:0]   m_axis_tdata_o
);

  localparam int IB = tgs_pkg::INT_BITS;
  localparam int FB = tgs_pkg::FRAC_BITS;
  localparam int SB = tgs_pkg::SAMPLE_BITS;
  localparam int RB = tgs_pkg::REG_BITS;
  localparam int CB = tgs_pkg::COORD_BITS;
  localparam int CNT_BITS = 4;

  // Interpolation schedule, in sequencer cycles
  localparam logic [CNT_BITS-1:0] T_LAST_FETCH = 4'd7;
  localparam logic [CNT_BITS-1:0] T_FIRST_E    = 4'd3;
  localparam logic [CNT_BITS-1:0] T_LAUNCH_F1  = 4'd7;
  localparam logic [CNT_BITS-1:0] T_WRITE_F1   = 4'd8;
  localparam logic [CNT_BITS-1:0] T_LAUNCH_F2  = 4'd10;
  localparam logic [CNT_BITS-1:0] T_WRITE_F2   = 4'd11;
  localparam logic [CNT_BITS-1:0] T_LAUNCH_Z   = 4'd12;
  localparam logic [CNT_BITS-1:0] T_END        = 4'd13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_INTERP,
    ST_DONE
  } state_e;

  // Control registers
  state_e                state_q, state_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  m_tvalid_q, m_tvalid_d;
  logic [RB-1:0]         width_used_q, height_used_q, depth_used_q;

  // Payload registers
  tgs_pkg::cmd_e         cmd_q;
  logic [IB-1:0]         xi_q, yi_q, zi_q;
  logic [FB-1:0]         fx_q, fy_q, fz_q;
  logic [SB-1:0]         sample_q;
  logic signed [SB-1:0]  lo_q;
  logic signed [SB-1:0]  e_q [4];
  logic signed [SB-1:0]  f1_q, f2_q;
  logic signed [SB-1:0]  res_value_q, res_value_d;
  logic                  res_status_q, res_status_d;
  logic signed [SB-1:0]  m_value_q;
  logic                  m_status_q;
  logic signed [tgs_pkg::PROD_BITS-1:0] mul_q;
  logic signed [SB-1:0]  mula_q;

  // Combinational signals
  logic                  s_acc;
  logic                  out_free;
  logic [RB-1:0]         lim_x, lim_y, lim_z;
  logic                  oob;
  logic [IB-1:0]         xh, yh, zh;
  logic [2:0]            corner;
  logic                  ram_en, ram_we;
  logic [tgs_pkg::ADDR_BITS-1:0] ram_addr;
  logic [SB-1:0]         ram_rdata;
  logic signed [SB-1:0]  op_a, op_b;
  logic [FB-1:0]         op_f;
  logic signed [tgs_pkg::DIFF_BITS-1:0] diff;
  logic signed [tgs_pkg::PROD_BITS-1:0] prod;
  logic signed [tgs_pkg::SUM_BITS-1:0]  blend_sum;
  logic [1:0]            e_idx;
  logic                  cnt_odd;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_tvalid_q || m_axis_tready_i;

  // Saturate grid sizes to the store dimension
  assign lim_x = (width_used_q  > RB'(tgs_pkg::GRID_DIM)) ? RB'(tgs_pkg::GRID_DIM) : width_used_q;
  assign lim_y = (height_used_q > RB'(tgs_pkg::GRID_DIM)) ? RB'(tgs_pkg::GRID_DIM) : height_used_q;
  assign lim_z = (depth_used_q  > RB'(tgs_pkg::GRID_DIM)) ? RB'(tgs_pkg::GRID_DIM) : depth_used_q;

  assign oob = (RB'(xi_q) >= lim_x) || (RB'(yi_q) >= lim_y) || (RB'(zi_q) >= lim_z);

  // Upper neighbors, clamped at the last index in use
  assign xh = (RB'(xi_q) + RB'(1) < lim_x) ? xi_q + IB'(1) : xi_q;
  assign yh = (RB'(yi_q) + RB'(1) < lim_y) ? yi_q + IB'(1) : yi_q;
  assign zh = (RB'(zi_q) + RB'(1) < lim_z) ? zi_q + IB'(1) : zi_q;

  // Corner k: bit 0 selects upper x, bit 1 upper y, bit 2 upper z
  assign corner = cnt_q[2:0];

  // RAM port control
  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = {zi_q, yi_q, xi_q};
    unique case (state_q)
      ST_DECODE: begin
        if (!oob && (cmd_q == tgs_pkg::CMD_WRITE || cmd_q == tgs_pkg::CMD_READ)) begin
          ram_en = 1'b1;
          ram_we = (cmd_q == tgs_pkg::CMD_WRITE);
        end
      end
      ST_INTERP: begin
        if (cnt_q <= T_LAST_FETCH) begin
          ram_en   = 1'b1;
          ram_addr = {corner[2] ? zh : zi_q, corner[1] ? yh : yi_q, corner[0] ? xh : xi_q};
        end
      end
      default: ;
    endcase
  end

  tgs_ram #(
    .WIDTH (SB),
    .DEPTH (tgs_pkg::GRID_DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (sample_q),
    .rdata_o (ram_rdata)
  );

  // Blend operand select per schedule step
  always_comb begin
    op_a = lo_q;
    op_b = $signed(ram_rdata);
    op_f = fx_q;
    case (cnt_q)
      T_LAUNCH_F1: begin
        op_a = e_q[0];
        op_b = e_q[1];
        op_f = fy_q;
      end
      T_LAUNCH_F2: begin
        op_a = e_q[2];
        op_b = e_q[3];
        op_f = fy_q;
      end
      T_LAUNCH_Z: begin
        op_a = f1_q;
        op_b = f2_q;
        op_f = fz_q;
      end
      default: ;
    endcase
  end

  // Blend stage one: (b - a) * f
  assign diff = $signed({op_b[SB-1], op_b}) - $signed({op_a[SB-1], op_a});
  assign prod = $signed({{(tgs_pkg::PROD_BITS - tgs_pkg::DIFF_BITS){diff[tgs_pkg::DIFF_BITS-1]}},
                         diff})
              * $signed({{(tgs_pkg::PROD_BITS - FB){1'b0}}, op_f});

  // Blend stage two: a + floor(product / 2^FRAC_BITS)
  assign blend_sum = $signed(mul_q[tgs_pkg::PROD_BITS-1:FB])
                   + $signed({{(tgs_pkg::SUM_BITS - SB){mula_q[SB-1]}}, mula_q});

  assign e_idx   = 2'((cnt_q - T_FIRST_E) >> 1);
  assign cnt_odd = cnt_q[0];

  // Sequencer next state and result
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    m_tvalid_d   = m_tvalid_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    if (m_tvalid_q && m_axis_tready_i) begin
      m_tvalid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_value_d  = '0;
        res_status_d = 1'b0;
        state_d      = ST_DONE;
        case (cmd_q) inside
          tgs_pkg::CMD_WRITE, tgs_pkg::CMD_READ, tgs_pkg::CMD_INTERP: begin
            if (oob) begin
              res_status_d = 1'b1;
            end else if (cmd_q == tgs_pkg::CMD_READ) begin
              state_d = ST_READ;
            end else if (cmd_q == tgs_pkg::CMD_INTERP) begin
              state_d = ST_INTERP;
              cnt_d   = '0;
            end
          end
          default: ;
        endcase
      end
      ST_READ: begin
        res_value_d = $signed(ram_rdata);
        state_d     = ST_DONE;
      end
      ST_INTERP: begin
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == T_END) begin
          res_value_d = blend_sum[SB-1:0];
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state, step counter, output valid and grid sizes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      m_tvalid_q    <= 1'b0;
      width_used_q  <= RB'(tgs_pkg::GRID_DIM);
      height_used_q <= RB'(tgs_pkg::GRID_DIM);
      depth_used_q  <= RB'(tgs_pkg::GRID_DIM);
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      m_tvalid_q <= m_tvalid_d;
      if (cfg_we_i) begin
        unique case (tgs_pkg::cfg_idx_e'(cfg_idx_i))
          tgs_pkg::CFG_WIDTH_USED:  width_used_q  <= cfg_data_i;
          tgs_pkg::CFG_HEIGHT_USED: height_used_q <= cfg_data_i;
          tgs_pkg::CFG_DEPTH_USED:  depth_used_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload: item fields, blend pipeline, partial results, output beat
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cmd_q    <= tgs_pkg::cmd_e'(s_axis_tdata_i[tgs_pkg::S_CMD_LSB +: tgs_pkg::CMD_BITS]);
      xi_q     <= s_axis_tdata_i[tgs_pkg::S_X_LSB + FB +: IB];
      yi_q     <= s_axis_tdata_i[tgs_pkg::S_Y_LSB + FB +: IB];
      zi_q     <= s_axis_tdata_i[tgs_pkg::S_Z_LSB + FB +: IB];
      fx_q     <= s_axis_tdata_i[tgs_pkg::S_X_LSB +: FB];
      fy_q     <= s_axis_tdata_i[tgs_pkg::S_Y_LSB +: FB];
      fz_q     <= s_axis_tdata_i[tgs_pkg::S_Z_LSB +: FB];
      sample_q <= s_axis_tdata_i[tgs_pkg::S_SAMPLE_LSB +: SB];
    end
    mul_q        <= prod;
    mula_q       <= op_a;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    if (state_q == ST_INTERP) begin
      // capture the lower-x corner of each pair
      if (cnt_odd && cnt_q <= T_LAST_FETCH) begin
        lo_q <= $signed(ram_rdata);
      end
      // x blends land on odd steps three to nine
      if (cnt_odd && cnt_q >= T_FIRST_E && cnt_q <= T_FIRST_E + CNT_BITS'(6)) begin
        e_q[e_idx] <= blend_sum[SB-1:0];
      end
      if (cnt_q == T_WRITE_F1) begin
        f1_q <= blend_sum[SB-1:0];
      end
      if (cnt_q == T_WRITE_F2) begin
        f2_q <= blend_sum[SB-1:0];
      end
    end
    if (state_q == ST_DONE && out_free) begin
      m_value_q  <= res_value_q;
      m_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = {{(tgs_pkg::M_TDATA_BITS - tgs_pkg::M_USED_BITS){1'b0}},
                            m_status_q, m_value_q};

  // Coordinate width check keeps the beat layout honest
  localparam int CoordCheck = CB;

`include "assert_macros.svh"

  `ASSERT_CLK(a_accept_to_decode, s_acc |=> (state_q == ST_DECODE), "accepted beat not decoded")
  `ASSERT_CLK(a_write_only_decode,
              (ram_en && ram_we) |->
                (state_q == ST_DECODE && !oob && cmd_q == tgs_pkg::CMD_WRITE),
              "RAM write outside a valid write command")
  `ASSERT_CLK(a_result_from_done,
              $rose(m_tvalid_q) |-> $past(state_q == ST_DONE),
              "output beat raised outside done state")
  `ASSERT_CLK(a_interp_step_bound,
              (state_q == ST_INTERP) |-> (cnt_q <= T_END),
              "interpolation step past end of schedule")
  `ASSERT_CLK(a_hold_until_taken,
              (state_q == ST_DONE && m_tvalid_q && !m_axis_tready_i) |=>
                (state_q == ST_DONE && m_tvalid_q),
              "pending result dropped while output stalled")
  `ASSERT_ALWAYS(a_coord_layout,
                 CoordCheck == tgs_pkg::S_Y_LSB - tgs_pkg::S_X_LSB,
                 "coordinate field width mismatch")

endmodule

// ----- src/tgs_ram.sv -----
// Generic single-port synchronous RAM with a registered read port.
// No dependencies; instantiated by trilinear_grid_sampler_top.
module tgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sim/tb_trilinear_grid_sampler_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for trilinear_grid_sampler_top: directed rows, then random beats
// under several grid sizes, results held to row values or a local trilinear predictor.
// Depends on tgs_pkg and the RTL of the sampler.
module tb_trilinear_grid_sampler_top;
  import tgs_pkg::*;

  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   SETTLE_CYCLES  = 24;
  localparam int   IDLE_PCT       = 35;
  localparam int   HOLD_START     = 3000;
  localparam int   HOLD_CYCLES    = 250;
  localparam cmd_e CMD_UNUSED     = cmd_e'(2'd3);

  typedef logic [COORD_BITS-1:0] coord_t;

  // input beat fields, last field in the lowest bits
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    coord_t                        z;
    coord_t                        y;
    coord_t                        x;
    cmd_e                          cmd;
  } in_beat_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] value;
    logic                   status;
  } sample_result_t;

  typedef struct {
    bit             fixed;
    sample_result_t res;
  } typed_answer_t;

  typedef struct {
    bit       is_cfg;
    cfg_idx_e idx;
    int       cfg_val;
    cmd_e     cmd;
    int       xc;
    int       yc;
    int       zc;
    int       sample;
    bit       fixed;
    int       value;
    bit       status;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [REG_BITS-1:0]     cfg_data_i = '0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [S_TDATA_BITS-1:0] s_axis_tdata_i = '0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [M_TDATA_BITS-1:0] m_axis_tdata_o;

  // predictor state, updated at each accepted beat or register write
  bit signed [SAMPLE_BITS-1:0] grid_shadow [GRID_DEPTH];
  logic [REG_BITS-1:0]         width_reg  = REG_BITS'(GRID_DIM);
  logic [REG_BITS-1:0]         height_reg = REG_BITS'(GRID_DIM);
  logic [REG_BITS-1:0]         depth_reg  = REG_BITS'(GRID_DIM);

  // stimulus-side view: which entries have been sent a write, and the sizes in force
  bit                  gen_written [GRID_DEPTH];
  logic [REG_BITS-1:0] gen_w = REG_BITS'(GRID_DIM);
  logic [REG_BITS-1:0] gen_h = REG_BITS'(GRID_DIM);
  logic [REG_BITS-1:0] gen_d = REG_BITS'(GRID_DIM);

  typed_answer_t  typed_answers_q [$];
  sample_result_t due_samples_q [$];
  stim_row_t      stim_tab [$];
  int             mismatches = 0;
  bit             calm = 1'b0;

  trilinear_grid_sampler_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int grid_limit(logic [REG_BITS-1:0] r);
    return (r > GRID_DIM) ? GRID_DIM : int'(r);
  endfunction

  function automatic int grid_addr(int xi, int yi, int zi);
    return (zi * GRID_DIM + yi) * GRID_DIM + xi;
  endfunction

  function automatic int qc(int ip, int fr);
    return (ip << FRAC_BITS) | fr;
  endfunction

  // a + floor((b - a) * f / 2^FRAC_BITS)
  function automatic int mix_linear(int a, int b, int f);
    return a + (((b - a) * f) >>> FRAC_BITS);
  endfunction

  // Predict one result and apply the beat to the shadow grid.
  function automatic sample_result_t interp_predict(in_beat_t b);
    sample_result_t r;
    int lx, ly, lz, xi, yi, zi, xh, yh, zh, fx, fy, fz;
    int e1, e2, e3, e4, f1, f2;
    r.value  = '0;
    r.status = 1'b0;
    lx = grid_limit(width_reg);
    ly = grid_limit(height_reg);
    lz = grid_limit(depth_reg);
    xi = int'(b.x[COORD_BITS-1:FRAC_BITS]);
    yi = int'(b.y[COORD_BITS-1:FRAC_BITS]);
    zi = int'(b.z[COORD_BITS-1:FRAC_BITS]);
    fx = int'(b.x[FRAC_BITS-1:0]);
    fy = int'(b.y[FRAC_BITS-1:0]);
    fz = int'(b.z[FRAC_BITS-1:0]);
    if (b.cmd == CMD_WRITE || b.cmd == CMD_READ || b.cmd == CMD_INTERP) begin
      if (xi >= lx || yi >= ly || zi >= lz) begin
        r.status = 1'b1;
      end else begin
        case (b.cmd)
          CMD_WRITE: begin
            grid_shadow[grid_addr(xi, yi, zi)] = b.sample;
          end
          CMD_READ: begin
            r.value = grid_shadow[grid_addr(xi, yi, zi)];
          end
          default: begin
            // clamp the upper corner at the last index in use
            xh = (xi + 1 < lx) ? xi + 1 : xi;
            yh = (yi + 1 < ly) ? yi + 1 : yi;
            zh = (zi + 1 < lz) ? zi + 1 : zi;
            e1 = mix_linear(grid_shadow[grid_addr(xi, yi, zi)],
                            grid_shadow[grid_addr(xh, yi, zi)], fx);
            e2 = mix_linear(grid_shadow[grid_addr(xi, yh, zi)],
                            grid_shadow[grid_addr(xh, yh, zi)], fx);
            e3 = mix_linear(grid_shadow[grid_addr(xi, yi, zh)],
                            grid_shadow[grid_addr(xh, yi, zh)], fx);
            e4 = mix_linear(grid_shadow[grid_addr(xi, yh, zh)],
                            grid_shadow[grid_addr(xh, yh, zh)], fx);
            f1 = mix_linear(e1, e2, fy);
            f2 = mix_linear(e3, e4, fy);
            r.value = SAMPLE_BITS'(mix_linear(f1, f2, fz));
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic bit inside_grid_gen(int xi, int yi, int zi);
    return xi < grid_limit(gen_w) && yi < grid_limit(gen_h) && zi < grid_limit(gen_d);
  endfunction

  // True unless the beat would read an entry that no write has reached yet.
  function automatic bit corners_ready(cmd_e c, int xi, int yi, int zi);
    int xh, yh, zh;
    if (!inside_grid_gen(xi, yi, zi)) return 1'b1;
    if (c == CMD_READ) return gen_written[grid_addr(xi, yi, zi)];
    if (c != CMD_INTERP) return 1'b1;
    xh = (xi + 1 < grid_limit(gen_w)) ? xi + 1 : xi;
    yh = (yi + 1 < grid_limit(gen_h)) ? yi + 1 : yi;
    zh = (zi + 1 < grid_limit(gen_d)) ? zi + 1 : zi;
    return gen_written[grid_addr(xi, yi, zi)] && gen_written[grid_addr(xh, yi, zi)] &&
           gen_written[grid_addr(xi, yh, zi)] && gen_written[grid_addr(xh, yh, zi)] &&
           gen_written[grid_addr(xi, yi, zh)] && gen_written[grid_addr(xh, yi, zh)] &&
           gen_written[grid_addr(xi, yh, zh)] && gen_written[grid_addr(xh, yh, zh)];
  endfunction

  function automatic int pick_index(int lim);
    int r, span;
    r = $urandom_range(99);
    if (lim == 0 || r >= 80) return $urandom_range(GRID_DIM - 1);
    span = (lim > 4) ? 3 : lim - 1;
    if (r < 45) return $urandom_range(span);
    return lim - 1 - $urandom_range(span);
  endfunction

  function automatic int pick_frac();
    case ($urandom_range(9))
      0: return 0;
      1: return (1 << FRAC_BITS) - 1;
      default: return $urandom_range((1 << FRAC_BITS) - 1);
    endcase
  endfunction

  function automatic stim_row_t beat_row(cmd_e c, int xc, int yc, int zc, int s,
                                         bit fixed = 1'b0, int v = 0, bit st = 1'b0);
    stim_row_t r;
    r = '{is_cfg: 1'b0, idx: CFG_WIDTH_USED, cfg_val: 0, cmd: c, xc: xc, yc: yc, zc: zc,
          sample: s, fixed: fixed, value: v, status: st};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(cfg_idx_e idx, int v);
    stim_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, cfg_val: v, cmd: CMD_WRITE, xc: 0, yc: 0, zc: 0,
          sample: 0, fixed: 1'b0, value: 0, status: 1'b0};
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one beat, at times with a random gap ahead of it; return at the edge that takes it.
  task automatic offer_beat(cmd_e c, int xc, int yc, int zc, int s,
                            bit fixed = 1'b0, int v = 0, bit st = 1'b0);
    in_beat_t                b;
    logic [S_TDATA_BITS-1:0] word;
    typed_answer_t           ans;
    bit                      rdy;
    int                      xi, yi, zi;
    b.cmd    = c;
    b.x      = COORD_BITS'(xc);
    b.y      = COORD_BITS'(yc);
    b.z      = COORD_BITS'(zc);
    b.sample = SAMPLE_BITS'(s);
    word     = '0;
    word[S_USED_BITS-1:0] = b;
    xi = xc >> FRAC_BITS;
    yi = yc >> FRAC_BITS;
    zi = zc >> FRAC_BITS;
    if (c == CMD_WRITE && inside_grid_gen(xi, yi, zi)) gen_written[grid_addr(xi, yi, zi)] = 1'b1;
    ans.fixed      = fixed;
    ans.res.value  = SAMPLE_BITS'(v);
    ans.res.status = st;
    typed_answers_q.push_back(ans);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 24 : 5)) @(posedge clk_i);
    end
    s_axis_tdata_i  <= word;
    s_axis_tvalid_i <= 1'b1;
    // sample ready mid-cycle, then pass the edge that decides the handshake
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready_o;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // Drop valid and wait until every result is back and the sequencer has gone quiet.
  task automatic settle_block();
    s_axis_tvalid_i <= 1'b0;
    while (typed_answers_q.size() != 0 || due_samples_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int v);
    settle_block();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= REG_BITS'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WIDTH_USED:  gen_w = REG_BITS'(v);
      CFG_HEIGHT_USED: gen_h = REG_BITS'(v);
      default:         gen_d = REG_BITS'(v);
    endcase
  endtask

  task automatic random_beats(int count);
    cmd_e c;
    int   xi, yi, zi, r;
    repeat (count) begin
      xi = pick_index(grid_limit(gen_w));
      yi = pick_index(grid_limit(gen_h));
      zi = pick_index(grid_limit(gen_d));
      r  = $urandom_range(99);
      if (r < 30)      c = CMD_WRITE;
      else if (r < 55) c = CMD_READ;
      else if (r < 95) c = CMD_INTERP;
      else             c = CMD_UNUSED;
      // turn a read of unwritten corners into a write at the base point
      if (!corners_ready(c, xi, yi, zi)) c = CMD_WRITE;
      offer_beat(c, qc(xi, pick_frac()), qc(yi, pick_frac()), qc(zi, pick_frac()),
                 $urandom_range(16'hFFFF));
    end
  endtask

  // Predict at each accepted input beat, check each accepted output beat.
  always @(posedge clk_i) begin
    in_beat_t               b;
    typed_answer_t          ans;
    sample_result_t         pred;
    sample_result_t         want;
    logic [SAMPLE_BITS-1:0] got_value;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH_USED:  width_reg  = cfg_data_i;
          CFG_HEIGHT_USED: height_reg = cfg_data_i;
          CFG_DEPTH_USED:  depth_reg  = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_value = m_axis_tdata_o[M_VALUE_LSB +: SAMPLE_BITS];
        if (due_samples_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending, value %0d",
                                    $signed(got_value)));
        end else begin
          want = due_samples_q.pop_front();
          if (got_value !== want.value)
            report_mismatch($sformatf("value got %0d want %0d",
                                      $signed(got_value), $signed(want.value)));
          if (m_axis_tdata_o[M_STATUS_LSB] !== want.status)
            report_mismatch($sformatf("status got %b want %b",
                                      m_axis_tdata_o[M_STATUS_LSB], want.status));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        b    = s_axis_tdata_i[S_USED_BITS-1:0];
        pred = interp_predict(b);
        ans.fixed = 1'b0;
        if (typed_answers_q.size() != 0) ans = typed_answers_q.pop_front();
        due_samples_q.push_back(ans.fixed ? ans.res : pred);
      end
    end
  end

  // Output ready: random stalls, one long hold-off, no random stalls while calm.
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) m_axis_tready_i <= 1'b0;
      else m_axis_tready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Stop the run when no beat moves on either side for too long.
  initial begin
    int stall;
    stall = 0;
    while (stall < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        stall = 0;
      else
        stall++;
    end
    $display("trilinear_grid_sampler_top: mismatch");
    $finish;
  end

  initial begin
    int n;
    // directed rows: extremes, every command, clamping and out-of-grid cases
    stim_tab.push_back(beat_row(CMD_WRITE, qc(0, 0), 0, 0, 32767, 1'b1, 0, 1'b0));
    stim_tab.push_back(beat_row(CMD_WRITE, qc(1, 'h7F), 0, 0, -32768, 1'b1, 0, 1'b0));
    stim_tab.push_back(beat_row(CMD_WRITE, qc(0, 0), qc(1, 0), 0, 1000));
    stim_tab.push_back(beat_row(CMD_WRITE, qc(1, 0), qc(1, 0), 0, -1000));
    stim_tab.push_back(beat_row(CMD_WRITE, qc(0, 0), 0, qc(1, 0), 12345));
    stim_tab.push_back(beat_row(CMD_WRITE, qc(1, 0), 0, qc(1, 0), -20000));
    stim_tab.push_back(beat_row(CMD_WRITE, qc(0, 0), qc(1, 0), qc(1, 0), 'h55));
    stim_tab.push_back(beat_row(CMD_WRITE, qc(1, 0), qc(1, 0), qc(1, 0), -1));
    stim_tab.push_back(beat_row(CMD_READ, 0, 0, 0, 0, 1'b1, 32767, 1'b0));
    stim_tab.push_back(beat_row(CMD_READ, qc(1, 'hFF), qc(0, 'hFF), qc(0, 1), 0,
                                1'b1, -32768, 1'b0));
    stim_tab.push_back(beat_row(CMD_INTERP, 0, 0, 0, 0, 1'b1, 32767, 1'b0));
    stim_tab.push_back(beat_row(CMD_INTERP, qc(0, 'hFF), qc(0, 'hFF), qc(0, 'hFF), 0));
    stim_tab.push_back(beat_row(CMD_INTERP, qc(0, 'h80), qc(0, 'h80), qc(0, 'h80), 0));
    stim_tab.push_back(beat_row(CMD_WRITE, 'h1FFF, 'h1FFF, 'h1FFF, -32768, 1'b1, 0, 1'b0));
    stim_tab.push_back(beat_row(CMD_READ, 'h1FFF, 'h1FFF, 'h1FFF, 0, 1'b1, -32768, 1'b0));
    stim_tab.push_back(beat_row(CMD_INTERP, 'h1FFF, 'h1FFF, 'h1FFF, 0, 1'b1, -32768, 1'b0));
    stim_tab.push_back(beat_row(CMD_UNUSED, 'h1FFF, 'h1FFF, 'h1FFF, -1, 1'b1, 0, 1'b0));
    stim_tab.push_back(cfg_row(CFG_WIDTH_USED, 1));
    stim_tab.push_back(beat_row(CMD_INTERP, qc(0, 'h80), qc(0, 'h40), qc(0, 'hC0), 0));
    stim_tab.push_back(beat_row(CMD_READ, qc(1, 0), 0, 0, 0, 1'b1, 0, 1'b1));
    stim_tab.push_back(beat_row(CMD_WRITE, qc(1, 0), 0, 0, 7, 1'b1, 0, 1'b1));
    stim_tab.push_back(cfg_row(CFG_WIDTH_USED, 0));
    stim_tab.push_back(beat_row(CMD_READ, 0, 0, 0, 0, 1'b1, 0, 1'b1));
    stim_tab.push_back(cfg_row(CFG_WIDTH_USED, 63));
    stim_tab.push_back(beat_row(CMD_READ, 'h1F00, 'h1F00, 'h1F00, 0, 1'b1, -32768, 1'b0));
    stim_tab.push_back(beat_row(CMD_READ, qc(1, 0), 0, 0, 0, 1'b1, -32768, 1'b0));

    // hold reset, then release on an edge
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed rows
    foreach (stim_tab[i]) begin
      if (stim_tab[i].is_cfg)
        write_reg(stim_tab[i].idx, stim_tab[i].cfg_val);
      else
        offer_beat(stim_tab[i].cmd, stim_tab[i].xc, stim_tab[i].yc, stim_tab[i].zc,
                   stim_tab[i].sample, stim_tab[i].fixed, stim_tab[i].value,
                   stim_tab[i].status);
    end

    // random beats under a series of grid sizes
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          write_reg(CFG_WIDTH_USED, 32); write_reg(CFG_HEIGHT_USED, 32);
          write_reg(CFG_DEPTH_USED, 32); n = 250;
        end
        1: begin
          write_reg(CFG_WIDTH_USED, 5); write_reg(CFG_HEIGHT_USED, 3);
          write_reg(CFG_DEPTH_USED, 7); n = 200;
        end
        2: begin
          write_reg(CFG_WIDTH_USED, 63); write_reg(CFG_HEIGHT_USED, 40);
          write_reg(CFG_DEPTH_USED, 33); n = 200;
        end
        3: begin
          write_reg(CFG_WIDTH_USED, 1); write_reg(CFG_HEIGHT_USED, 1);
          write_reg(CFG_DEPTH_USED, 1); n = 100;
        end
        4: begin
          write_reg(CFG_WIDTH_USED, 2); write_reg(CFG_HEIGHT_USED, 32);
          write_reg(CFG_DEPTH_USED, 17); n = 200;
        end
        5: begin
          write_reg(CFG_WIDTH_USED, 32); write_reg(CFG_HEIGHT_USED, 0);
          write_reg(CFG_DEPTH_USED, 32); n = 40;
        end
        default: begin
          write_reg(CFG_WIDTH_USED, $urandom_range(1, 33));
          write_reg(CFG_HEIGHT_USED, $urandom_range(1, 33));
          write_reg(CFG_DEPTH_USED, $urandom_range(1, 33)); n = 210;
        end
      endcase
      // one phase runs with no idling on either side
      calm = (p == 1);
      random_beats(n);
      calm = 1'b0;
    end

    // drain, then give late or extra results time to show up
    settle_block();
    repeat (16) @(posedge clk_i);
    if (due_samples_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_samples_q.size()));
    if (mismatches == 0)
      $display("trilinear_grid_sampler_top: match");
    else
      $display("trilinear_grid_sampler_top: mismatch");
    $finish;
  end

endmodule
